/* hw/rtl/nearest_color_classifier_defines.svh */
// assertion helpers for the rtl
`ifndef NEAREST_COLOR_CLASSIFIER_DEFINES_SVH
`define NEAREST_COLOR_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checks held off while in reset
`define NCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks held off while in reset
`define NCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ncc_pkg.sv */
`default_nettype none

package ncc_pkg;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int TYPE_W  = 8;
  localparam int INDEX_W = 4;
  localparam int CFG_W   = 5;
  localparam int SQ_W    = 16;
  localparam int DIST_W  = 18;

  // request kinds
  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  // one reference table entry as stored in the ram
  typedef struct packed {
    logic              known;
    logic [TYPE_W-1:0] kind_code;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/ncc_ram.sv */
`default_nettype none

module ncc_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nearest_color_classifier.sv */
// nearest_color_classifier
// Holds a table of TABLE_DEPTH reference colors and finds the known entry
// nearest to a sample color in squared rgb distance.
// Request channel: a request is taken at a clock edge with start high and busy
// low. A load request (in_kind 0) writes one table entry at that edge, gives
// no result and leaves busy low, so one load can follow another every cycle.
// A classify request (in_kind 1) raises busy and scans entries 0 .. L-1, with
// L = min(entries_in_use, TABLE_DEPTH), one table read per cycle through the
// single ram read port followed by a square stage and a compare stage.
// Result: out_valid is high for one cycle, registered once the scan and the
// square and compare stages are done; an exact match ends the scan early.
// busy is low again in the out_valid cycle, so the next request can be taken
// then. The receiver cannot stall: a result is gone after its one cycle.
// Configuration: cfg_we writes entries_in_use from cfg_wdata at the edge; it
// is to be written only while the block is idle, which the block does not enforce.
// Reset (rst_n low, synchronous) marks all entries unknown through a row of
// valid flops, clears entries_in_use and drops busy and out_valid; there is
// no clearing pass over the ram.

`default_nettype none
`include "nearest_color_classifier_defines.svh"

module nearest_color_classifier #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_kind,
  input  wire logic [ncc_pkg::INDEX_W-1:0] in_entry_index,
  input  wire logic [ncc_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [ncc_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [ncc_pkg::CHAN_W-1:0]  in_blue,
  input  wire logic [ncc_pkg::TYPE_W-1:0]  in_entry_type,
  input  wire logic                        in_entry_known,
  // result channel
  output logic                             out_valid,
  output logic [ncc_pkg::TYPE_W-1:0]       out_color_type,
  output logic                             out_exact_match,
  output logic [ncc_pkg::DIST_W-1:0]       out_best_distance_sq,
  output logic                             out_found_any,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [ncc_pkg::CFG_W-1:0]   cfg_wdata
);

  import ncc_pkg::*;

  localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = IW + INDEX_W;

  // state
  state_t                  state_r, state_nxt;
  logic [CFG_W-1:0]        entries_in_use_r, entries_in_use_nxt;
  logic [TABLE_DEPTH-1:0]  valid_r, valid_nxt;
  logic [CW-1:0]           limit_r, limit_nxt;
  logic [CW-1:0]           rd_cnt_r, rd_cnt_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic                    vb_r, vb_nxt;
  logic                    s1_vld_r, s1_vld_nxt;
  logic                    stop_r, stop_nxt;
  logic [CHAN_W-1:0]       samp_red_r, samp_red_nxt;
  logic [CHAN_W-1:0]       samp_green_r, samp_green_nxt;
  logic [CHAN_W-1:0]       samp_blue_r, samp_blue_nxt;
  logic [SQ_W-1:0]         sq_red_r, sq_red_nxt;
  logic [SQ_W-1:0]         sq_green_r, sq_green_nxt;
  logic [SQ_W-1:0]         sq_blue_r, sq_blue_nxt;
  logic                    s1_known_r, s1_known_nxt;
  logic [TYPE_W-1:0]       s1_type_r, s1_type_nxt;
  logic [DIST_W-1:0]       best_r, best_nxt;
  logic [TYPE_W-1:0]       best_type_r, best_type_nxt;
  logic                    have_r, have_nxt;
  logic                    exact_r, exact_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TYPE_W-1:0]       out_type_r, out_type_nxt;
  logic                    out_exact_r, out_exact_nxt;
  logic [DIST_W-1:0]       out_dist_r, out_dist_nxt;
  logic                    out_found_r, out_found_nxt;

  // combinational helpers
  logic                    accept;
  logic                    load_we;
  logic [EXT_W-1:0]        idx_ext;
  logic [IW-1:0]           wr_addr;
  logic [IW-1:0]           rd_addr;
  entry_t                  wr_ent;
  entry_t                  rd_ent;
  logic [ENTRY_W-1:0]      ram_rdata;
  logic                    issue;
  logic                    all_done;
  logic [CW-1:0]           lim_sat;
  logic [CHAN_W-1:0]       d_red, d_green, d_blue;
  logic [DIST_W-1:0]       dist_sum;

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;

  // load request decode, out-of-table slots are dropped
  assign idx_ext = EXT_W'(in_entry_index);
  assign wr_addr = idx_ext[IW-1:0];
  assign load_we = accept && (in_kind == KIND_LOAD) &&
                   (32'(in_entry_index) < TABLE_DEPTH);

  always_comb begin
    wr_ent.known     = in_entry_known;
    wr_ent.kind_code = in_entry_type;
    wr_ent.red       = in_red;
    wr_ent.green     = in_green;
    wr_ent.blue      = in_blue;
  end

  // scan read issue, one entry per cycle until the limit or a stop
  assign issue   = (state_r == ST_SCAN) && !stop_r && (rd_cnt_r != limit_r);
  assign rd_addr = rd_cnt_r[IW-1:0];

  ncc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // saturate the searched count at the table depth
  always_comb begin
    if (32'(entries_in_use_r) > TABLE_DEPTH) begin
      lim_sat = CW'(TABLE_DEPTH);
    end else begin
      lim_sat = CW'(entries_in_use_r);
    end
  end

  // per-channel absolute differences on the read data
  always_comb begin
    d_red   = (rd_ent.red   >= samp_red_r)   ? (rd_ent.red   - samp_red_r)
                                             : (samp_red_r   - rd_ent.red);
    d_green = (rd_ent.green >= samp_green_r) ? (rd_ent.green - samp_green_r)
                                             : (samp_green_r - rd_ent.green);
    d_blue  = (rd_ent.blue  >= samp_blue_r)  ? (rd_ent.blue  - samp_blue_r)
                                             : (samp_blue_r  - rd_ent.blue);
  end

  // distance from the registered squares
  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

  assign all_done = stop_r ||
                    ((rd_cnt_r == limit_r) && !rd_vld_r && !s1_vld_r);

  // next-state logic
  always_comb begin
    state_nxt          = state_r;
    entries_in_use_nxt = entries_in_use_r;
    valid_nxt          = valid_r;
    limit_nxt          = limit_r;
    rd_cnt_nxt         = rd_cnt_r;
    stop_nxt           = stop_r;
    samp_red_nxt       = samp_red_r;
    samp_green_nxt     = samp_green_r;
    samp_blue_nxt      = samp_blue_r;
    best_nxt           = best_r;
    best_type_nxt      = best_type_r;
    have_nxt           = have_r;
    exact_nxt          = exact_r;
    out_valid_nxt      = 1'b0;
    out_type_nxt       = out_type_r;
    out_exact_nxt      = out_exact_r;
    out_dist_nxt       = out_dist_r;
    out_found_nxt      = out_found_r;

    // configuration write
    if (cfg_we) begin
      entries_in_use_nxt = cfg_wdata;
    end

    // entry becomes valid once written
    if (load_we) begin
      valid_nxt[wr_addr] = 1'b1;
    end

    // read pipeline valids, flushed by a stop
    rd_vld_nxt = issue;
    vb_nxt     = valid_r[rd_addr];
    s1_vld_nxt = rd_vld_r && (state_r == ST_SCAN) && !stop_r;

    // square stage
    sq_red_nxt   = SQ_W'(d_red)   * SQ_W'(d_red);
    sq_green_nxt = SQ_W'(d_green) * SQ_W'(d_green);
    sq_blue_nxt  = SQ_W'(d_blue)  * SQ_W'(d_blue);
    s1_known_nxt = vb_r && rd_ent.known;
    s1_type_nxt  = rd_ent.kind_code;

    if (issue) begin
      rd_cnt_nxt = rd_cnt_r + CW'(1);
    end

    // compare stage: exact match stops, earlier entry wins a tie
    if (s1_vld_r && !stop_r && s1_known_r) begin
      if (dist_sum == '0) begin
        best_nxt      = '0;
        best_type_nxt = s1_type_r;
        have_nxt      = 1'b1;
        exact_nxt     = 1'b1;
        stop_nxt      = 1'b1;
      end else if (!have_r || (dist_sum < best_r)) begin
        best_nxt      = dist_sum;
        best_type_nxt = s1_type_r;
        have_nxt      = 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_CLASSIFY)) begin
          state_nxt      = ST_SCAN;
          limit_nxt      = lim_sat;
          rd_cnt_nxt     = '0;
          stop_nxt       = 1'b0;
          samp_red_nxt   = in_red;
          samp_green_nxt = in_green;
          samp_blue_nxt  = in_blue;
          best_nxt       = '0;
          best_type_nxt  = '0;
          have_nxt       = 1'b0;
          exact_nxt      = 1'b0;
        end
      end
      ST_SCAN: begin
        if (all_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_type_nxt  = best_type_r;
          out_exact_nxt = exact_r;
          out_dist_nxt  = best_r;
          out_found_nxt = have_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      entries_in_use_r <= '0;
      valid_r          <= '0;
      rd_cnt_r         <= '0;
      limit_r          <= '0;
      rd_vld_r         <= 1'b0;
      s1_vld_r         <= 1'b0;
      stop_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      entries_in_use_r <= entries_in_use_nxt;
      valid_r          <= valid_nxt;
      rd_cnt_r         <= rd_cnt_nxt;
      limit_r          <= limit_nxt;
      rd_vld_r         <= rd_vld_nxt;
      s1_vld_r         <= s1_vld_nxt;
      stop_r           <= stop_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vb_r         <= vb_nxt;
    samp_red_r   <= samp_red_nxt;
    samp_green_r <= samp_green_nxt;
    samp_blue_r  <= samp_blue_nxt;
    sq_red_r     <= sq_red_nxt;
    sq_green_r   <= sq_green_nxt;
    sq_blue_r    <= sq_blue_nxt;
    s1_known_r   <= s1_known_nxt;
    s1_type_r    <= s1_type_nxt;
    best_r       <= best_nxt;
    best_type_r  <= best_type_nxt;
    have_r       <= have_nxt;
    exact_r      <= exact_nxt;
    out_type_r   <= out_type_nxt;
    out_exact_r  <= out_exact_nxt;
    out_dist_r   <= out_dist_nxt;
    out_found_r  <= out_found_nxt;
  end

  // result ports
  assign out_valid            = out_valid_r;
  assign out_color_type       = out_type_r;
  assign out_exact_match      = out_exact_r;
  assign out_best_distance_sq = out_dist_r;
  assign out_found_any        = out_found_r;

  // terms for the checks
  logic exact_hit, exact_ok, none_hit, none_ok, classify_acc;

  assign exact_hit    = out_valid && out_exact_match;
  assign exact_ok     = (out_best_distance_sq == '0) && out_found_any;
  assign none_hit     = out_valid && !out_found_any;
  assign none_ok      = (out_color_type == '0) && (out_best_distance_sq == '0) &&
                        !out_exact_match;
  assign classify_acc = start && !busy && (in_kind == KIND_CLASSIFY);

  // checks
  `NCC_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")
  `NCC_ASSERT_SAME(a_exact_zero, clk, rst_n, exact_hit, exact_ok, "exact match not zero")
  `NCC_ASSERT_SAME(a_none_zero, clk, rst_n, none_hit, none_ok, "empty search result not zero")
  `NCC_ASSERT_SAME(a_cnt_bound, clk, rst_n, busy, rd_cnt_r <= limit_r, "scan read past limit")
  `NCC_ASSERT_NEXT(a_classify_busy, clk, rst_n, classify_acc, busy, "classify did not scan")

endmodule

`default_nettype wire

/* tb/sv/tb_color_match_pkg.sv */
`timescale 1ns / 100ps

package tb_color_match_pkg;
  import ncc_pkg::*;

  localparam int TB_DEPTH = 16;

  // one classify result as seen on the result ports
  typedef struct packed {
    logic [TYPE_W-1:0] color_type;
    logic              exact_match;
    logic [DIST_W-1:0] best_dsq;
    logic              found_any;
  } match_t;

  // keeps a copy of the color table and the nearest matches still owed
  class color_match_sb;
    entry_t           colors[TB_DEPTH];
    logic [CFG_W-1:0] entries_in_use;
    match_t           pending_matches[$];
    int               fail_count = 0;
    int               load_count = 0;
    int               classify_count = 0;
    int               exact_count = 0;
    int               empty_count = 0;

    function new();
      foreach (colors[i]) colors[i] = '0;
      entries_in_use = '0;
    endfunction

    // nearest known entry among the searched slots, earlier slot wins ties
    function match_t find_nearest(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                  logic [CHAN_W-1:0] b);
      match_t m;
      int     span;
      int     dr;
      int     dg;
      int     db;
      int     dsq;
      m = '0;
      span = (entries_in_use > TB_DEPTH) ? TB_DEPTH : int'(entries_in_use);
      for (int i = 0; i < span; i++) begin
        if (colors[i].known) begin
          dr = int'(colors[i].red) - int'(r);
          dg = int'(colors[i].green) - int'(g);
          db = int'(colors[i].blue) - int'(b);
          dsq = dr * dr + dg * dg + db * db;
          // exact hit ends the search
          if (dsq == 0) begin
            m.color_type = colors[i].kind_code;
            m.exact_match = 1'b1;
            m.best_dsq = '0;
            m.found_any = 1'b1;
            break;
          end
          if (!m.found_any || dsq < int'(m.best_dsq)) begin
            m.color_type = colors[i].kind_code;
            m.best_dsq = dsq[DIST_W-1:0];
            m.found_any = 1'b1;
          end
        end
      end
      return m;
    endfunction

    // an accepted request: a load updates the table, a classify owes a result
    function void note_request(logic kind, logic [INDEX_W-1:0] idx,
                               logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                               logic [CHAN_W-1:0] b, logic [TYPE_W-1:0] typ,
                               logic known);
      match_t m;
      if (kind == KIND_LOAD) begin
        colors[idx].known = known;
        colors[idx].kind_code = typ;
        colors[idx].red = r;
        colors[idx].green = g;
        colors[idx].blue = b;
        load_count++;
      end else begin
        m = find_nearest(r, g, b);
        pending_matches.push_back(m);
        classify_count++;
        if (m.exact_match) exact_count++;
        if (!m.found_any) empty_count++;
      end
    endfunction

    function void log_fail(string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
    endfunction

    // compare a result with the oldest owed match
    function void check_match(match_t got);
      match_t want;
      if (pending_matches.size() == 0) begin
        log_fail($sformatf("unexpected result: type %0d exact %0d dsq %0d found %0d",
                           got.color_type, got.exact_match, got.best_dsq,
                           got.found_any));
      end else begin
        want = pending_matches.pop_front();
        if (got.color_type !== want.color_type || got.exact_match !== want.exact_match ||
            got.best_dsq !== want.best_dsq || got.found_any !== want.found_any) begin
          log_fail($sformatf({"mismatch: expected type %0d exact %0d dsq %0d found %0d,",
                              " got type %0d exact %0d dsq %0d found %0d"},
                             want.color_type, want.exact_match, want.best_dsq,
                             want.found_any, got.color_type, got.exact_match,
                             got.best_dsq, got.found_any));
        end
      end
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import ncc_pkg::*;
  import tb_color_match_pkg::*;

  localparam int ITEMS_TOTAL   = 1650;
  localparam int SETTLE_CYCLES = 24;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_kind;
  logic [INDEX_W-1:0]  in_entry_index;
  logic [CHAN_W-1:0]   in_red;
  logic [CHAN_W-1:0]   in_green;
  logic [CHAN_W-1:0]   in_blue;
  logic [TYPE_W-1:0]   in_entry_type;
  logic                in_entry_known;
  logic                out_valid;
  logic [TYPE_W-1:0]   out_color_type;
  logic                out_exact_match;
  logic [DIST_W-1:0]   out_best_distance_sq;
  logic                out_found_any;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  color_match_sb match_sb = new();
  match_t        seen_match;
  logic [CFG_W-1:0] table_size = '0;
  bit            quiet_sender = 1'b0;
  int            sent_count = 0;
  int            size_count = 0;

  nearest_color_classifier #(
    .TABLE_DEPTH(16)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_entry_index       (in_entry_index),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .in_entry_type        (in_entry_type),
    .in_entry_known       (in_entry_known),
    .out_valid            (out_valid),
    .out_color_type       (out_color_type),
    .out_exact_match      (out_exact_match),
    .out_best_distance_sq (out_best_distance_sq),
    .out_found_any        (out_found_any),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result monitor, samples pre-edge values
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      seen_match.color_type = out_color_type;
      seen_match.exact_match = out_exact_match;
      seen_match.best_dsq = out_best_distance_sq;
      seen_match.found_any = out_found_any;
      match_sb.check_match(seen_match);
    end
  end

  // drive one request and wait until it is taken
  task automatic send_request(input logic kind, input logic [INDEX_W-1:0] idx,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [TYPE_W-1:0] typ,
                              input logic known);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(5, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_entry_index <= idx;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_entry_type <= typ;
    in_entry_known <= known;
    @(posedge clk);
    while (busy) @(posedge clk);
    match_sb.note_request(kind, idx, r, g, b, typ, known);
    sent_count++;
  endtask

  // classify request, unused fields carry noise
  task automatic classify(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                          input logic [CHAN_W-1:0] b);
    send_request(KIND_CLASSIFY, INDEX_W'($urandom_range(15, 0)), r, g, b,
                 TYPE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
  endtask

  // stop sending until every owed result is in, then let the block settle
  task automatic drain_matches();
    start <= 1'b0;
    while (match_sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // entries_in_use write, block must be idle
  task automatic write_table_size(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    match_sb.entries_in_use = v;
    table_size = v;
    size_count++;
  endtask

  // slot mostly inside the searched range
  function automatic logic [INDEX_W-1:0] pick_slot();
    int span;
    span = (table_size == 0 || table_size > TB_DEPTH) ? TB_DEPTH : int'(table_size);
    if ($urandom_range(4, 0) == 0) span = TB_DEPTH;
    return INDEX_W'($urandom_range(span - 1, 0));
  endfunction

  // small random offset, clamped to the channel range
  function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6, 0)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  initial begin
    int     phase_len;
    int     choice;
    logic [INDEX_W-1:0] slot;
    entry_t e;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= KIND_LOAD;
    in_entry_index <= '0;
    in_red <= '0;
    in_green <= '0;
    in_blue <= '0;
    in_entry_type <= '0;
    in_entry_known <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty search with the reset table size
    classify(8'd0, 8'd0, 8'd0);
    drain_matches();
    write_table_size(CFG_W'(16));
    // full table, nothing known yet
    classify(8'd255, 8'd255, 8'd255);
    // largest distance
    send_request(KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd0, 8'hA5, 1'b1);
    classify(8'd255, 8'd255, 8'd255);
    // exact hit in the last slot and in the first
    send_request(KIND_LOAD, 4'd15, 8'd255, 8'd255, 8'd255, 8'h5A, 1'b1);
    classify(8'd255, 8'd255, 8'd255);
    classify(8'd0, 8'd0, 8'd0);
    // ties go to the earlier slot
    send_request(KIND_LOAD, 4'd1, 8'd10, 8'd10, 8'd10, 8'd1, 1'b1);
    send_request(KIND_LOAD, 4'd2, 8'd10, 8'd10, 8'd10, 8'd2, 1'b1);
    classify(8'd12, 8'd10, 8'd10);
    send_request(KIND_LOAD, 4'd3, 8'd20, 8'd10, 8'd10, 8'd3, 1'b1);
    classify(8'd15, 8'd10, 8'd10);
    // two exact candidates, first one stops the search
    send_request(KIND_LOAD, 4'd4, 8'd100, 8'd100, 8'd100, 8'd4, 1'b1);
    send_request(KIND_LOAD, 4'd5, 8'd100, 8'd100, 8'd100, 8'd5, 1'b1);
    classify(8'd100, 8'd100, 8'd100);
    // unknown entry with the exact color is skipped
    send_request(KIND_LOAD, 4'd6, 8'd50, 8'd60, 8'd70, 8'hFF, 1'b0);
    classify(8'd50, 8'd60, 8'd70);
    send_request(KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd0, 8'h00, 1'b0);
    classify(8'd0, 8'd0, 8'd0);
    // oversized and tiny table sizes
    drain_matches();
    write_table_size(CFG_W'(31));
    classify(8'd255, 8'd0, 8'd255);
    drain_matches();
    write_table_size(CFG_W'(1));
    classify(8'd0, 8'd0, 8'd0);
    drain_matches();
    write_table_size(CFG_W'(17));
    classify(8'd200, 8'd200, 8'd200);

    // random phases, each with its own table size
    while (sent_count < ITEMS_TOTAL) begin
      drain_matches();
      case ($urandom_range(9, 0))
        0: write_table_size(CFG_W'(0));
        1: write_table_size(CFG_W'(1));
        2: write_table_size(CFG_W'(16));
        3: write_table_size(CFG_W'(17));
        4: write_table_size(CFG_W'(31));
        default: write_table_size(CFG_W'($urandom_range(15, 2)));
      endcase
      quiet_sender = ($urandom_range(3, 0) == 0);
      phase_len = $urandom_range(120, 40);
      repeat (phase_len) begin
        choice = $urandom_range(99, 0);
        slot = pick_slot();
        if (choice < 22) begin
          // fresh entry, mostly known
          send_request(KIND_LOAD, slot, CHAN_W'($urandom_range(255, 0)),
                       CHAN_W'($urandom_range(255, 0)), CHAN_W'($urandom_range(255, 0)),
                       TYPE_W'($urandom_range(255, 0)), 1'($urandom_range(6, 0) != 0));
        end else if (choice < 30) begin
          // copy of another entry's color for ties
          e = match_sb.colors[pick_slot()];
          send_request(KIND_LOAD, slot, e.red, e.green, e.blue,
                       TYPE_W'($urandom_range(255, 0)), 1'b1);
        end else if (choice < 50) begin
          e = match_sb.colors[slot];
          classify(e.red, e.green, e.blue);
        end else if (choice < 75) begin
          e = match_sb.colors[slot];
          classify(nudge(e.red), nudge(e.green), nudge(e.blue));
        end else if (choice < 78) begin
          drain_matches();
        end else begin
          classify(CHAN_W'($urandom_range(255, 0)), CHAN_W'($urandom_range(255, 0)),
                   CHAN_W'($urandom_range(255, 0)));
        end
      end
    end

    drain_matches();
    $display("run covered %0d requests (%0d loads, %0d classifies) over %0d table sizes",
             sent_count, match_sb.load_count, match_sb.classify_count, size_count);
    $display("%0d classifies hit an exact color, %0d found no known entry, %0d failures",
             match_sb.exact_count, match_sb.empty_count, match_sb.fail_count);
    if (match_sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ncc_pkg.sv
hw/rtl/ncc_ram.sv
hw/rtl/nearest_color_classifier.sv
tb/sv/tb_color_match_pkg.sv
tb/sv/tb_top.sv
